// ----- design/mdsa_pkg.sv -----
// ----------------------------------------------------------------------------
// mdsa_pkg - shared definitions for the max-distance slot allocator
// Sizes, request and status codes, and the scan control bundle.
// ----------------------------------------------------------------------------
package mdsa_pkg;

    localparam int MAX_SLOTS = 256;
    localparam int ROW_LIMIT = (MAX_SLOTS < 256) ? MAX_SLOTS : 256;
    localparam int ADDR_W    = $clog2(MAX_SLOTS);
    localparam int SLOT_W    = 8;
    localparam int CNT_W     = 9;
    localparam int STAT_W    = 2;

    localparam logic OP_TAKE    = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STAT_W-1:0] ST_TAKEN    = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd1;
    localparam logic [STAT_W-1:0] ST_RELEASED = 2'd2;
    localparam logic [STAT_W-1:0] ST_IGNORED  = 2'd3;

    typedef struct packed {
        logic              clear;  // restart the search
        logic              step;   // one map bit is presented
        logic              occ;    // the map bit
        logic [SLOT_W-1:0] idx;    // slot the bit belongs to
    } scan_ctl_t;

endpackage

// ----- design/max_distance_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// max_distance_slot_allocator - seat allocator that maximizes spacing
// Keeps an occupancy map of a row and hands out the most isolated free slot.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries requests: s_opcode selects take or release, s_position names
//   the slot to release. m_* returns one result per request: m_slot and
//   m_status (taken, row full, released, release of a free slot ignored).
//   cfg_* writes slot_count, the row length; write it only while idle.
//   The block works on one request at a time and drops s_ready meanwhile.
//   A take scans the map one slot per cycle through the map RAM's read port,
//   over the clamped row length; a take on a full row skips the scan.
//   After reset the map RAM is cleared one slot per cycle, all MAX_SLOTS (256)
//   of them, with s_ready low; configuration writes are taken throughout.
//   A new request is accepted while the previous result still waits on
//   m_ready; a finished result then holds in its state until the output
//   register frees up.
// ----------------------------------------------------------------------------
module max_distance_slot_allocator
    import mdsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // request channel
    input  logic              s_valid,
    output logic              s_ready,
    input  logic              s_opcode,
    input  logic [SLOT_W-1:0] s_position,
    // result channel
    output logic              m_valid,
    input  logic              m_ready,
    output logic [SLOT_W-1:0] m_slot,
    output logic [STAT_W-1:0] m_status,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CNT_W-1:0]  cfg_data
);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;
    localparam logic [2:0] S_RREAD  = 3'd5;
    localparam logic [2:0] S_RCHECK = 3'd6;
    localparam logic [2:0] S_OUT    = 3'd7;

    localparam logic [CNT_W-1:0]  ROW_MAX  = CNT_W'(ROW_LIMIT);
    localparam logic [ADDR_W-1:0] CLR_LAST = ADDR_W'(MAX_SLOTS - 1);

    logic [2:0]        state_reg,     state_next;
    logic [ADDR_W-1:0] clr_idx_reg,   clr_idx_next;
    logic [SLOT_W-1:0] rd_idx_reg,    rd_idx_next;
    logic              pv_reg,        pv_next;
    logic [SLOT_W-1:0] pidx_reg,      pidx_next;
    logic [SLOT_W-1:0] last_slot_reg, last_slot_next;
    logic [SLOT_W-1:0] pos_reg,       pos_next;
    logic [CNT_W-1:0]  count_reg,     count_next;
    logic [CNT_W-1:0]  slot_cnt_reg,  slot_cnt_next;
    logic [SLOT_W-1:0] res_slot_reg,  res_slot_next;
    logic [STAT_W-1:0] res_stat_reg,  res_stat_next;
    logic              m_valid_reg,   m_valid_next;
    logic [SLOT_W-1:0] m_slot_reg,    m_slot_next;
    logic [STAT_W-1:0] m_status_reg,  m_status_next;

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic              ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic              ram_rdata;

    logic [CNT_W-1:0]  row_len;
    scan_ctl_t         scan_ctl;
    logic [SLOT_W-1:0] pick;

    // Clamp the configured row length to 1 .. ROW_LIMIT.
    always_comb begin
        if (slot_cnt_reg == '0) begin
            row_len = CNT_W'(1);
        end else if (slot_cnt_reg > ROW_MAX) begin
            row_len = ROW_MAX;
        end else begin
            row_len = slot_cnt_reg;
        end
    end

    assign s_ready   = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_slot    = m_slot_reg;
    assign m_status  = m_status_reg;

    // The scan reads one slot a cycle; the unit sees it in the cycle after.
    assign ram_raddr = (state_reg == S_SCAN) ? ADDR_W'(rd_idx_reg) : ADDR_W'(pos_reg);

    always_comb begin
        scan_ctl.clear = (state_reg == S_IDLE);
        scan_ctl.step  = pv_reg;
        scan_ctl.occ   = ram_rdata;
        scan_ctl.idx   = pidx_reg;
    end

    always_comb begin
        state_next     = state_reg;
        clr_idx_next   = clr_idx_reg;
        rd_idx_next    = rd_idx_reg;
        pv_next        = (state_reg == S_SCAN);
        pidx_next      = rd_idx_reg;
        last_slot_next = last_slot_reg;
        pos_next       = pos_reg;
        count_next     = count_reg;
        slot_cnt_next  = slot_cnt_reg;
        res_slot_next  = res_slot_reg;
        res_stat_next  = res_stat_reg;
        m_valid_next   = m_valid_reg;
        m_slot_next    = m_slot_reg;
        m_status_next  = m_status_reg;
        ram_we         = 1'b0;
        ram_waddr      = clr_idx_reg;
        ram_wdata      = 1'b0;

        if (cfg_valid) begin
            slot_cnt_next = cfg_data;
        end

        // Drop the output once taken; a new result may reload it below.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_CLEAR: begin
                ram_we       = 1'b1;
                clr_idx_next = clr_idx_reg + ADDR_W'(1);
                if (clr_idx_reg == CLR_LAST) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                if (s_valid) begin
                    pos_next = s_position;
                    if (s_opcode == OP_RELEASE) begin
                        res_slot_next = s_position;
                        res_stat_next = ST_IGNORED;
                        if (32'(s_position) < MAX_SLOTS) begin
                            state_next = S_RREAD;
                        end else begin
                            state_next = S_OUT;
                        end
                    end else if (count_reg >= row_len) begin
                        res_slot_next = '0;
                        res_stat_next = ST_FULL;
                        state_next    = S_OUT;
                    end else begin
                        last_slot_next = SLOT_W'(row_len - CNT_W'(1));
                        rd_idx_next    = '0;
                        state_next     = S_SCAN;
                    end
                end
            end
            S_SCAN: begin
                rd_idx_next = rd_idx_reg + SLOT_W'(1);
                if (rd_idx_reg == last_slot_reg) begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN: begin
                state_next = S_FINISH;
            end
            S_FINISH: begin
                // Mark the chosen slot and count it.
                ram_we        = 1'b1;
                ram_waddr     = ADDR_W'(pick);
                ram_wdata     = 1'b1;
                count_next    = count_reg + CNT_W'(1);
                res_slot_next = pick;
                res_stat_next = ST_TAKEN;
                state_next    = S_OUT;
            end
            S_RREAD: begin
                state_next = S_RCHECK;
            end
            S_RCHECK: begin
                if (ram_rdata) begin
                    ram_we        = 1'b1;
                    ram_waddr     = ADDR_W'(pos_reg);
                    ram_wdata     = 1'b0;
                    res_stat_next = ST_RELEASED;
                    if (count_reg != '0) begin
                        count_next = count_reg - CNT_W'(1);
                    end
                end
                state_next = S_OUT;
            end
            S_OUT: begin
                // Hold the result until the output register is free.
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_slot_next   = res_slot_reg;
                    m_status_next = res_stat_reg;
                    state_next    = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_CLEAR;
            clr_idx_reg  <= '0;
            pv_reg       <= 1'b0;
            count_reg    <= '0;
            slot_cnt_reg <= CNT_W'(256);
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            clr_idx_reg  <= clr_idx_next;
            pv_reg       <= pv_next;
            count_reg    <= count_next;
            slot_cnt_reg <= slot_cnt_next;
            m_valid_reg  <= m_valid_next;
        end
        rd_idx_reg    <= rd_idx_next;
        pidx_reg      <= pidx_next;
        last_slot_reg <= last_slot_next;
        pos_reg       <= pos_next;
        res_slot_reg  <= res_slot_next;
        res_stat_reg  <= res_stat_next;
        m_slot_reg    <= m_slot_next;
        m_status_reg  <= m_status_next;
    end

    mdsa_ram #(
        .WIDTH (1),
        .DEPTH (MAX_SLOTS)
    ) u_map (
        .aclk    (aclk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_addr (ram_raddr),
        .rd_data (ram_rdata)
    );

    mdsa_gap_unit u_gap (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .ctl       (scan_ctl),
        .last_slot (last_slot_reg),
        .pick      (pick)
    );

endmodule

// ----- design/mdsa_ram.sv -----
// ----------------------------------------------------------------------------
// mdsa_ram - generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; no reset on the array.
// ----------------------------------------------------------------------------
module mdsa_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/mdsa_gap_unit.sv -----
// ----------------------------------------------------------------------------
// mdsa_gap_unit - widest-gap search, one map bit per cycle
// Tracks the last occupied slot and the best pick so far: left edge or interior midpoint.
// ----------------------------------------------------------------------------
module mdsa_gap_unit
    import mdsa_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  scan_ctl_t         ctl,
    input  logic [SLOT_W-1:0] last_slot,
    output logic [SLOT_W-1:0] pick
);

    logic              seen_reg,  seen_next;
    logic [SLOT_W-1:0] last_reg,  last_next;
    logic [SLOT_W-1:0] best_reg,  best_next;
    logic [SLOT_W-1:0] dist_reg,  dist_next;

    logic [SLOT_W:0]   pair_sum;
    logic [SLOT_W-1:0] mid;
    logic [SLOT_W-1:0] mid_dist;
    logic [SLOT_W-1:0] edge_dist;

    // Midpoint of the gap that closes at this slot; a touching pair gives zero.
    assign pair_sum = {1'b0, last_reg} + {1'b0, ctl.idx};
    assign mid      = pair_sum[SLOT_W:1];
    assign mid_dist = mid - last_reg;

    always_comb begin
        seen_next = seen_reg;
        last_next = last_reg;
        best_next = best_reg;
        dist_next = dist_reg;
        if (ctl.clear) begin
            seen_next = 1'b0;
            last_next = '0;
            best_next = '0;
            dist_next = '0;
        end else if (ctl.step && ctl.occ) begin
            if (!seen_reg) begin
                seen_next = 1'b1;
                best_next = '0;
                dist_next = ctl.idx;
            end else if (mid_dist > dist_reg) begin
                best_next = mid;
                dist_next = mid_dist;
            end
            last_next = ctl.idx;
        end
    end

    // Right edge wins only when strictly farther than the best so far.
    assign edge_dist = last_slot - last_reg;

    always_comb begin
        if (!seen_reg) begin
            pick = '0;
        end else if (last_reg != last_slot && edge_dist > dist_reg) begin
            pick = last_slot;
        end else begin
            pick = best_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else begin
            seen_reg <= seen_next;
        end
        last_reg <= last_next;
        best_reg <= best_next;
        dist_reg <= dist_next;
    end

endmodule
